### rtl/sspp_pkg.sv
// Shared types and constants of the servo status packet parser.
package sspp_pkg;

  localparam logic [7:0] HdrByte = 8'hFF;
  localparam int unsigned NumCapt = 9;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SERVO   = 2'd1,
    ST_CORRUPT = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       reply_start;
    logic [7:0] requested_id;
  } item_t;

  typedef struct packed {
    logic [7:0]  target_id;
    logic [7:0]  reply_id;
    logic [7:0]  error_flags;
    logic [15:0] position_word;
    logic [15:0] speed_word;
    logic [15:0] load_word;
    status_e     status;
  } result_t;

endpackage

### rtl/sspp_if.sv
// Valid/ready channel interfaces for received bytes and parsed results.
interface sspp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       reply_start;
  logic [7:0] requested_id;

  modport source (output valid, output rx_byte, output reply_start,
                  output requested_id, input ready);
  modport sink (input valid, input rx_byte, input reply_start,
                input requested_id, output ready);
endinterface

interface sspp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  target_id;
  logic [7:0]  reply_id;
  logic [7:0]  error_flags;
  logic [15:0] position_word;
  logic [15:0] speed_word;
  logic [15:0] load_word;
  logic [1:0]  status;

  modport source (output valid, output target_id, output reply_id, output error_flags,
                  output position_word, output speed_word, output load_word,
                  output status, input ready);
  modport sink (input valid, input target_id, input reply_id, input error_flags,
                input position_word, input speed_word, input load_word,
                input status, output ready);
endinterface

### rtl/sspp_frame.sv
// Frame state machine: header check, byte capture, checksum and result build.
module sspp_frame (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  sspp_pkg::item_t   item_i,
  output logic              res_valid_o,
  output sspp_pkg::result_t res_o
);
  import sspp_pkg::*;

  localparam logic [3:0] PhIdle    = 4'd0;
  localparam logic [3:0] PhHdr2Ok  = 4'd1;
  localparam logic [3:0] PhHdr2Bad = 4'd2;
  localparam logic [3:0] PhId      = 4'd3;
  localparam logic [3:0] PhDataEnd = 4'd11;
  localparam logic [3:0] PhCheck   = 4'd12;
  localparam logic [3:0] PhDiscard = 4'd13;

  logic [3:0] phase_q, phase_d;
  logic [7:0] target_q, target_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] capt_q [NumCapt];
  logic       capt_we;
  logic [3:0] capt_idx;

  assign capt_idx = phase_q - PhId;

  always_comb begin
    phase_d     = phase_q;
    target_d    = target_q;
    sum_d       = sum_q;
    capt_we     = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{target_id: target_q, reply_id: capt_q[0], error_flags: capt_q[2],
                    position_word: {capt_q[4], capt_q[3]},
                    speed_word: {capt_q[6], capt_q[5]},
                    load_word: {capt_q[8], capt_q[7]}, status: ST_OK};
    if (item_i.reply_start) begin
      // restart: this byte is the first header byte
      target_d = item_i.requested_id;
      sum_d    = '0;
      phase_d  = (item_i.rx_byte == HdrByte) ? PhHdr2Ok : PhHdr2Bad;
    end else begin
      case (phase_q)
        PhHdr2Ok, PhHdr2Bad: begin
          if (phase_q == PhHdr2Ok && item_i.rx_byte == HdrByte) begin
            phase_d = PhId;
          end else begin
            res_valid_o         = 1'b1;
            res_o.reply_id      = '0;
            res_o.error_flags   = '0;
            res_o.position_word = '0;
            res_o.speed_word    = '0;
            res_o.load_word     = '0;
            res_o.status        = ST_CORRUPT;
            phase_d             = PhDiscard;
          end
        end
        PhCheck: begin
          res_valid_o = 1'b1;
          if (item_i.rx_byte != ~sum_q) begin
            res_o.status = ST_CORRUPT;
          end else if (capt_q[2] != '0) begin
            res_o.status = ST_SERVO;
          end else begin
            res_o.status = ST_OK;
          end
          phase_d = PhDiscard;
        end
        default: begin
          if (phase_q >= PhId && phase_q <= PhDataEnd) begin
            capt_we = 1'b1;
            sum_d   = sum_q + item_i.rx_byte;
            phase_d = phase_q + 4'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      target_q <= '0;
      sum_q    <= '0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      target_q <= target_d;
      sum_q    <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && capt_we) begin
      capt_q[capt_idx] <= item_i.rx_byte;
    end
  end

  a_start_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.reply_start |-> !res_valid_o)
    else $error("result raised on a reply start byte");

  a_ok_means_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && res_valid_o && res_o.status == ST_OK) |-> res_o.error_flags == '0)
    else $error("ok status with nonzero servo error byte");

  a_capture_ends_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && !item_i.reply_start && phase_q == PhDataEnd) |=> phase_q == PhCheck)
    else $error("capture did not advance to checksum phase");

endmodule

### rtl/sspp_out_reg.sv
// Result register driving the output channel.
module sspp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  sspp_pkg::result_t data_i,
  output logic              free_o,
  sspp_out_if.source        res_o
);
  import sspp_pkg::*;

  logic    valid_q;
  result_t data_q;

  // free when empty or when the held result transfers this cycle
  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= data_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.target_id     = data_q.target_id;
  assign res_o.reply_id      = data_q.reply_id;
  assign res_o.error_flags   = data_q.error_flags;
  assign res_o.position_word = data_q.position_word;
  assign res_o.speed_word    = data_q.speed_word;
  assign res_o.load_word     = data_q.load_word;
  assign res_o.status        = 2'(data_q.status);

endmodule

### rtl/servo_status_packet_parser_top.sv
// Top level of the servo status packet parser.
//
// Usage:
//   rx_i carries the reply bytes of a servo, one byte per transfer, together
//   with reply_start (set on the first byte after a read request) and the
//   requested id. res_o carries one result per reply: the latched target id,
//   the reply id, the servo error byte, position/speed/load words and a status
//   (ok, servo error, corrupt). A bad header gives a corrupt result on the
//   second header byte; a good frame gives its result on the checksum byte.
//   Other bytes give no result.
// Timing:
//   A byte lands in the input register; once the result register is free, the
//   frame logic updates its state and loads the result register, so a result
//   reaches res_o through the input and then the result register. One byte is
//   taken every cycle while res_o is not stalled; the input register sets the rate.
// Reset and stalls:
//   Reset returns the parser to idle (waiting for reply start) and empties
//   both registers. When the receiver holds off res_o with a result pending,
//   the input register holds its byte and rx_i.ready drops until it drains.
module servo_status_packet_parser_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  sspp_in_if.sink   rx_i,
  sspp_out_if.source res_o
);
  import sspp_pkg::*;

  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_free;
  logic    adv;
  logic    res_valid;
  result_t res;

  // process the held byte when the result register can take whatever it yields
  assign adv        = s1_valid_q && out_free;
  assign rx_i.ready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      s1_valid_q <= rx_i.valid;
    end
  end

  // capture the byte on transfer; hold it while stalled
  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      s1_item_q <= '{rx_byte: rx_i.rx_byte, reply_start: rx_i.reply_start,
                     requested_id: rx_i.requested_id};
    end
  end

  sspp_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .item_i      (s1_item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sspp_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (adv && res_valid),
    .data_i (res),
    .free_o (out_free),
    .res_o  (res_o)
  );

  a_result_from_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(adv && res_valid))
    else $error("result appeared without a processed byte");

  a_stalled_byte_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("input register lost a byte while stalled");

endmodule
